>>> hw/rtl/tcs_pkg.sv
// tcs_pkg: sizes, codes, payload types and controller types of the text console scroller
// no dependencies; every other file of the block but tcs_ram refers to it by scoped names
`default_nettype none

package tcs_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam int         TAB_STEP    = 4;
    localparam logic [7:0] RESET_COLOR = 8'd15;

    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_value;
        logic        scrolled;
    } result_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY,
        S_FILL,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
        logic copy;
        logic fill;
    } ctl_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       will_scroll;
        logic       read_ok;
        logic       copy_done;
        logic       fill_done;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcs_ram.sv
// tcs_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcs_ctrl.sv
// tcs_ctrl: controller state machine of the text console scroller
// depends on tcs_pkg; drives the datapath through tcs_pkg::ctl_t
`default_nettype none

module tcs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire tcs_pkg::sts_t sts,
    output tcs_pkg::ctl_t      ctl,
    output logic               busy,
    output logic               done
);

    tcs_pkg::state_t state_reg;
    tcs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcs_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            tcs_pkg::S_INIT:
            begin
                ctl.fill = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = tcs_pkg::S_IDLE;
                end
            end
            tcs_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = tcs_pkg::S_EXEC;
                end
            end
            tcs_pkg::S_EXEC:
            begin
                ctl.exec = 1'b1;
                unique case (sts.mode)
                    tcs_pkg::MODE_CHAR:
                        state_next = sts.will_scroll ? tcs_pkg::S_COPY : tcs_pkg::S_RESP;
                    tcs_pkg::MODE_CLEAR:
                        state_next = tcs_pkg::S_FILL;
                    tcs_pkg::MODE_READ:
                        state_next = sts.read_ok ? tcs_pkg::S_READ : tcs_pkg::S_RESP;
                    default:
                        state_next = tcs_pkg::S_RESP;
                endcase
            end
            tcs_pkg::S_READ:
            begin
                ctl.capture = 1'b1;
                state_next  = tcs_pkg::S_RESP;
            end
            tcs_pkg::S_COPY:
            begin
                ctl.copy = 1'b1;
                if (sts.copy_done)
                begin
                    state_next = tcs_pkg::S_FILL;
                end
            end
            tcs_pkg::S_FILL:
            begin
                ctl.fill = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = tcs_pkg::S_RESP;
                end
            end
            tcs_pkg::S_RESP:
            begin
                done       = 1'b1;
                state_next = tcs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcs_datapath.sv
// tcs_datapath: cursor, color register, sweep counter and screen ram of the console
// depends on tcs_pkg and tcs_ram; steered by tcs_ctrl through ctl_t and sts_t
`default_nettype none

module tcs_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tcs_pkg::cmd_item_t   cmd,
    input  wire logic                 text_color_we,
    input  wire logic [7:0]           text_color_wdata,
    input  wire tcs_pkg::ctl_t        ctl,
    output tcs_pkg::sts_t             sts,
    output tcs_pkg::result_t          result
);

    localparam int AW = tcs_pkg::ADDR_W;
    localparam int RW = tcs_pkg::ROW_W;
    localparam int CW = tcs_pkg::COL_W;

    tcs_pkg::cmd_item_t        item_reg;
    logic [7:0]                color_reg;
    logic [RW-1:0]             cursor_row_reg;
    logic [CW-1:0]             cursor_col_reg;
    logic [AW-1:0]             cnt_reg;
    logic [tcs_pkg::CELL_W-1:0] fill_reg;
    logic [tcs_pkg::CELL_W-1:0] cell_reg;
    logic                      scrolled_reg;

    logic                      is_tab;
    logic                      is_newline;
    logic                      printable;
    logic [CW:0]               col_sum;
    logic                      wrap;
    logic                      last_row;
    logic                      will_scroll;
    logic                      read_ok;
    logic [AW-1:0]             cursor_idx;
    logic [AW-1:0]             read_idx;
    logic                      copy_done;
    logic                      fill_done;
    logic [tcs_pkg::CELL_W-1:0] color_cell;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [tcs_pkg::CELL_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [tcs_pkg::CELL_W-1:0] ram_rdata;

    assign is_tab     = (item_reg.char_code == tcs_pkg::CH_TAB);
    assign is_newline = (item_reg.char_code == tcs_pkg::CH_NEWLINE);
    assign printable  = !is_tab && !is_newline;
    assign col_sum    = {1'b0, cursor_col_reg}
                      + (is_tab ? (CW+1)'(tcs_pkg::TAB_STEP) : (CW+1)'(1));
    assign wrap       = is_newline || (col_sum >= (CW+1)'(tcs_pkg::COLS));
    assign last_row   = (cursor_row_reg == RW'(tcs_pkg::ROWS - 1));
    assign will_scroll = wrap && last_row;
    assign read_ok    = ({2'b00, item_reg.read_row} < 7'(tcs_pkg::ROWS))
                     && ({1'b0, item_reg.read_col} < 8'(tcs_pkg::COLS));
    assign cursor_idx = AW'(cursor_row_reg) * AW'(tcs_pkg::COLS) + AW'(cursor_col_reg);
    assign read_idx   = AW'(item_reg.read_row) * AW'(tcs_pkg::COLS) + AW'(item_reg.read_col);
    assign copy_done  = (cnt_reg == AW'(tcs_pkg::CELLS - tcs_pkg::COLS));
    assign fill_done  = (cnt_reg == AW'(tcs_pkg::CELLS - 1));
    assign color_cell = {color_reg, tcs_pkg::CH_SPACE};

    assign sts.mode        = item_reg.mode;
    assign sts.will_scroll = will_scroll;
    assign sts.read_ok     = read_ok;
    assign sts.copy_done   = copy_done;
    assign sts.fill_done   = fill_done;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = fill_reg;
        ram_re    = 1'b0;
        ram_raddr = cnt_reg + AW'(tcs_pkg::COLS);
        if (ctl.exec)
        begin
            ram_we    = (item_reg.mode == tcs_pkg::MODE_CHAR) && printable;
            ram_waddr = cursor_idx;
            ram_wdata = {color_reg, item_reg.char_code};
            ram_re    = (item_reg.mode == tcs_pkg::MODE_READ) && read_ok;
            ram_raddr = read_idx;
        end
        else if (ctl.copy)
        begin
            // write trails the read, storing the registered ram read data one row up
            ram_we    = (cnt_reg != '0);
            ram_waddr = cnt_reg - AW'(1);
            ram_wdata = ram_rdata;
            ram_re    = !copy_done;
        end
        else if (ctl.fill)
        begin
            ram_we = 1'b1;
        end
    end

    tcs_ram #(
        .WIDTH (tcs_pkg::CELL_W),
        .DEPTH (tcs_pkg::CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg      <= tcs_pkg::RESET_COLOR;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            cnt_reg        <= '0;
            fill_reg       <= {tcs_pkg::RESET_COLOR, tcs_pkg::CH_SPACE};
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            if (text_color_we)
            begin
                color_reg <= text_color_wdata;
            end
            if (ctl.exec)
            begin
                scrolled_reg <= 1'b0;
                unique case (item_reg.mode)
                    tcs_pkg::MODE_CHAR:
                    begin
                        if (wrap)
                        begin
                            cursor_col_reg <= '0;
                            if (!last_row)
                            begin
                                cursor_row_reg <= cursor_row_reg + RW'(1);
                            end
                            else
                            begin
                                scrolled_reg <= 1'b1;
                                cnt_reg      <= '0;
                                fill_reg     <= color_cell;
                            end
                        end
                        else
                        begin
                            cursor_col_reg <= col_sum[CW-1:0];
                        end
                    end
                    tcs_pkg::MODE_CLEAR:
                    begin
                        cursor_row_reg <= '0;
                        cursor_col_reg <= '0;
                        cnt_reg        <= '0;
                        fill_reg       <= color_cell;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (ctl.copy)
            begin
                if (!copy_done)
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                end
            end
            else if (ctl.fill)
            begin
                if (!fill_done)
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= cmd;
        end
        if (ctl.exec)
        begin
            cell_reg <= '0;
        end
        else if (ctl.capture)
        begin
            cell_reg <= ram_rdata;
        end
    end

    assign result.cursor_row = 5'(cursor_row_reg);
    assign result.cursor_col = cursor_col_reg;
    assign result.cell_value = cell_reg;
    assign result.scrolled   = scrolled_reg;

endmodule

`default_nettype wire

>>> hw/rtl/text_console_scroller_unit.sv
// text_console_scroller_unit: top level of the text console scroller
// depends on tcs_pkg, tcs_ctrl, tcs_datapath (which holds tcs_ram)
//
//  channel   ports                                  beat taken when
//  command   start, busy, cmd (cmd_item_t)          start && !busy
//  result    done, result (result_t)                done, one cycle only
//  color     text_color_we, text_color_wdata        text_color_we
//
// after reset the screen ram is swept to white spaces, all ROWS*COLS cells (2000), busy high
// character write and unused mode: accept, then S_EXEC, then the result beat in S_RESP
// cell read: S_EXEC, then S_READ for the registered ram read, then S_RESP
// scroll: S_EXEC, S_COPY, S_FILL, S_RESP, one ram copy or fill a cycle on the single write port
// clear: S_EXEC, S_FILL, S_RESP; the receiver cannot stall, results are never held
`default_nettype none

module text_console_scroller_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire tcs_pkg::cmd_item_t cmd,
    output logic                    busy,
    output logic                    done,
    output tcs_pkg::result_t        result,
    input  wire logic               text_color_we,
    input  wire logic [7:0]         text_color_wdata
);

    tcs_pkg::ctl_t ctl;
    tcs_pkg::sts_t sts;

    tcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    tcs_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .text_color_we    (text_color_we),
        .text_color_wdata (text_color_wdata),
        .ctl              (ctl),
        .sts              (sts),
        .result           (result)
    );

endmodule

`default_nettype wire
